>>> rtl/priority_dwrr_packet_scheduler_defines.svh
// Assertion macros used by the scheduler datapath.
`ifndef PRIORITY_DWRR_PACKET_SCHEDULER_DEFINES_SVH
`define PRIORITY_DWRR_PACKET_SCHEDULER_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define PDWRR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define PDWRR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pdwrr_pkg.sv
// Types and constants of the priority DWRR packet scheduler.
package pdwrr_pkg;

    localparam int NUM_CLASSES     = 4;
    localparam int QUEUE_DEPTH     = 64;
    localparam int PRIORITY_LEVELS = 8;

    localparam int CLS_W   = $clog2(NUM_CLASSES);
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int LVL_W   = $clog2(PRIORITY_LEVELS);
    localparam int RFILL_W = $clog2(NUM_CLASSES + 1);
    localparam int ADDR_W  = CLS_W + QPTR_W;
    localparam int STORE_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
    localparam int LEN_W   = 16;
    localparam int Q_W     = 16;
    localparam int DEF_W   = 17;
    localparam int ROUND_W = LEN_W + 1;
    localparam int PROD_W  = ROUND_W + Q_W;
    localparam int DIVCNT_W = $clog2(LEN_W);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W   = 16;
    localparam int STATUS_W = 3;

    localparam logic [DEF_W-1:0] DEFICIT_MAX = {DEF_W{1'b1}};

    typedef enum logic [STATUS_W-1:0] {
        ST_ENQUEUED   = 3'd0,
        ST_DROP_UNCFG = 3'd1,
        ST_DROP_FULL  = 3'd2,
        ST_DEQUEUED   = 3'd3,
        ST_EMPTY      = 3'd4
    } res_status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_Q0 = 3'd0, CFG_Q1 = 3'd1, CFG_Q2 = 3'd2, CFG_Q3 = 3'd3,
        CFG_P0 = 3'd4, CFG_P1 = 3'd5, CFG_P2 = 3'd6, CFG_P3 = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_IDLE, OP_ENQ, OP_FIND, OP_READ, OP_EVAL, OP_DIV,
        OP_RATIO, OP_MUL, OP_ADD, OP_SEND, OP_NONE
    } dp_op_t;

    typedef enum logic [3:0] {
        CS_IDLE, CS_ENQ, CS_FIND, CS_READ, CS_EVAL, CS_DIV,
        CS_RATIO, CS_CHECK, CS_MUL, CS_ADD, CS_SEND, CS_NONE
    } ctrl_state_t;

    typedef struct packed {
        logic   take;
        dp_op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic any_level;
        logic eval_div;
        logic idx_last;
        logic div_last;
        logic best_inf;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/pdwrr_if.sv
// Request and result channel interfaces of the scheduler.
interface pdwrr_req_if;
    import pdwrr_pkg::*;
    logic             valid;
    logic             ready;
    logic             command;
    logic [CLS_W-1:0] class_id;
    logic [LEN_W-1:0] packet_length;
    modport source (output valid, command, class_id, packet_length, input ready);
    modport sink   (input valid, command, class_id, packet_length, output ready);
endinterface

interface pdwrr_res_if;
    import pdwrr_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CLS_W-1:0]    served_class;
    logic [LEN_W-1:0]    served_length;
    modport source (output valid, status, served_class, served_length, input ready);
    modport sink   (input valid, status, served_class, served_length, output ready);
endinterface

>>> rtl/pdwrr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pdwrr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read one word per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/pdwrr_ctrl.sv
// Sequencer of the scheduler: steps the datapath through each request.
module pdwrr_ctrl import pdwrr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_command,
    output logic       req_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);
    ctrl_state_t state_reg, state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance and issue datapath operations
    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd.take   = 1'b0;
        cmd.op     = OP_IDLE;
        case (state_reg)
            CS_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = req_command ? CS_FIND : CS_ENQ;
                end
            end
            CS_ENQ:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_ENQ;
                    state_next = CS_IDLE;
                end
            end
            CS_FIND:
            begin
                cmd.op     = OP_FIND;
                state_next = status.any_level ? CS_READ : CS_NONE;
            end
            CS_READ:
            begin
                cmd.op     = OP_READ;
                state_next = CS_EVAL;
            end
            CS_EVAL:
            begin
                cmd.op = OP_EVAL;
                if (status.eval_div)
                begin
                    state_next = CS_DIV;
                end
                else
                begin
                    state_next = status.idx_last ? CS_CHECK : CS_READ;
                end
            end
            CS_DIV:
            begin
                cmd.op = OP_DIV;
                if (status.div_last)
                begin
                    state_next = CS_RATIO;
                end
            end
            CS_RATIO:
            begin
                cmd.op     = OP_RATIO;
                state_next = status.idx_last ? CS_CHECK : CS_READ;
            end
            CS_CHECK:
            begin
                state_next = status.best_inf ? CS_NONE : CS_MUL;
            end
            CS_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = CS_ADD;
            end
            CS_ADD:
            begin
                cmd.op     = OP_ADD;
                state_next = status.idx_last ? CS_SEND : CS_MUL;
            end
            CS_SEND:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_SEND;
                    state_next = CS_IDLE;
                end
            end
            CS_NONE:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_NONE;
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end
endmodule

>>> rtl/pdwrr_dp.sv
// Datapath of the scheduler: queues, rings, deficits, divider and result register.
module pdwrr_dp import pdwrr_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    input  logic [CLS_W-1:0]     req_class,
    input  logic [LEN_W-1:0]     req_length,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic [STATUS_W-1:0]  res_status,
    output logic [CLS_W-1:0]     res_class,
    output logic [LEN_W-1:0]     res_length
);
`include "priority_dwrr_packet_scheduler_defines.svh"

    // Configuration and scheduler state
    logic [Q_W-1:0]     quantum_reg [NUM_CLASSES];
    logic [LVL_W-1:0]   prio_reg    [NUM_CLASSES];
    logic [QPTR_W-1:0]  head_reg    [NUM_CLASSES];
    logic [FILL_W-1:0]  fill_reg    [NUM_CLASSES];
    logic [DEF_W-1:0]   deficit_reg [NUM_CLASSES];
    logic [CLS_W-1:0]   ring_reg    [PRIORITY_LEVELS][NUM_CLASSES];
    logic [CLS_W-1:0]   front_reg   [PRIORITY_LEVELS];
    logic [RFILL_W-1:0] rfill_reg   [PRIORITY_LEVELS];

    // Per-dequeue working registers
    logic [CLS_W-1:0]    cls_reg, cur_reg, w_reg, idx_reg;
    logic [LEN_W-1:0]    len_reg, head_len_reg, best_reg, win_len_reg;
    logic [LVL_W-1:0]    lvl_reg;
    logic [RFILL_W-1:0]  n_reg;
    logic                best_inf_reg;
    logic [CLS_W-1:0]    member_reg [NUM_CLASSES];
    logic [LEN_W-1:0]    rem_reg, quo_reg;
    logic [DIVCNT_W-1:0] div_cnt_reg;
    logic [PROD_W-1:0]   prod_reg;

    // Result register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [CLS_W-1:0]    out_class_reg;
    logic [LEN_W-1:0]    out_len_reg;

    // Length store
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [LEN_W-1:0]  ram_rdata;

    logic                any_level;
    logic [LVL_W-1:0]    top_lvl;
    logic                idx_last;
    logic [CLS_W-1:0]    rd_cls;
    logic [DEF_W-1:0]    cur_def;
    logic [Q_W-1:0]      cur_q;
    logic                eval_le;
    logic                eval_div;
    logic [LEN_W-1:0]    dividend;
    logic [LEN_W:0]      rem_sh;
    logic                div_ge;
    logic                cand_fin;
    logic [LEN_W-1:0]    cand;
    logic                cand_win;
    logic [ROUND_W-1:0]  rounds;
    logic [PROD_W:0]     def_sum;
    logic [CLS_W-1:0]    mem_cls;
    logic [CLS_W-1:0]    win_cls;
    logic [DEF_W-1:0]    win_def;
    logic                win_empties;
    logic [LVL_W-1:0]    enq_lvl;
    logic [CLS_W-1:0]    ring_slot;
    logic                enq_ok;
    logic                out_load;
    logic [STATUS_W-1:0] out_status_next;

    pdwrr_ram #(.WIDTH(LEN_W), .DEPTH(STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (len_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Find the highest non-empty level
    always_comb
    begin
        any_level = 1'b0;
        top_lvl   = '0;
        for (int l = 0; l < PRIORITY_LEVELS; l++)
        begin
            if (rfill_reg[l] != '0)
            begin
                any_level = 1'b1;
                top_lvl   = LVL_W'(l);
            end
        end
    end

    // Scan a ring member: address its head packet, rate its rounds
    assign idx_last  = ({1'b0, idx_reg} == RFILL_W'(n_reg - 1'b1));
    assign rd_cls    = ring_reg[lvl_reg][front_reg[lvl_reg] + idx_reg];
    assign ram_raddr = {rd_cls, head_reg[rd_cls]};
    assign cur_def   = deficit_reg[cur_reg];
    assign cur_q     = quantum_reg[cur_reg];
    assign eval_le   = ({1'b0, ram_rdata} <= cur_def);
    assign eval_div  = !eval_le && (cur_q != '0);
    assign dividend  = ram_rdata - cur_def[LEN_W-1:0] - 1'b1;
    assign rem_sh    = {rem_reg, quo_reg[LEN_W-1]};
    assign div_ge    = (rem_sh >= {1'b0, cur_q});

    always_comb
    begin
        cand_fin = 1'b0;
        cand     = '0;
        if (cmd.op == OP_EVAL)
        begin
            cand_fin = eval_le;
        end
        else if (cmd.op == OP_RATIO)
        begin
            cand_fin = 1'b1;
            cand     = quo_reg + 1'b1;
        end
        cand_win = cand_fin && (best_inf_reg || (cand < best_reg));
    end

    // Credit rounds to a member
    assign mem_cls = member_reg[idx_reg];
    assign rounds  = {1'b0, best_reg} + ROUND_W'(idx_reg < w_reg);
    assign def_sum = {{(PROD_W + 1 - DEF_W){1'b0}}, deficit_reg[mem_cls]} + {1'b0, prod_reg};

    // Serve the winner
    assign win_cls     = member_reg[w_reg];
    assign win_def     = deficit_reg[win_cls];
    assign win_empties = (fill_reg[win_cls] == FILL_W'(1));

    // Enqueue checks
    assign enq_lvl   = prio_reg[cls_reg];
    assign ring_slot = front_reg[enq_lvl] + rfill_reg[enq_lvl][CLS_W-1:0];
    assign enq_ok    = (quantum_reg[cls_reg] != '0) && (fill_reg[cls_reg] != FILL_W'(QUEUE_DEPTH));
    assign ram_we    = (cmd.op == OP_ENQ) && enq_ok;
    assign ram_waddr = {cls_reg, QPTR_W'(head_reg[cls_reg] + fill_reg[cls_reg][QPTR_W-1:0])};

    assign out_load = (cmd.op == OP_ENQ) || (cmd.op == OP_SEND) || (cmd.op == OP_NONE);

    always_comb
    begin
        case (cmd.op)
            OP_ENQ:
            begin
                if (quantum_reg[cls_reg] == '0)
                begin
                    out_status_next = ST_DROP_UNCFG;
                end
                else if (!enq_ok)
                begin
                    out_status_next = ST_DROP_FULL;
                end
                else
                begin
                    out_status_next = ST_ENQUEUED;
                end
            end
            OP_SEND: out_status_next = ST_DEQUEUED;
            default: out_status_next = ST_EMPTY;
        endcase
    end

    // Update control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                quantum_reg[c] <= '0;
                prio_reg[c]    <= '0;
                head_reg[c]    <= '0;
                fill_reg[c]    <= '0;
                deficit_reg[c] <= '0;
            end
            for (int l = 0; l < PRIORITY_LEVELS; l++)
            begin
                front_reg[l] <= '0;
                rfill_reg[l] <= '0;
            end
            idx_reg       <= '0;
            div_cnt_reg   <= '0;
            best_inf_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_Q0: quantum_reg[0] <= cfg_data[Q_W-1:0];
                    CFG_Q1: quantum_reg[1] <= cfg_data[Q_W-1:0];
                    CFG_Q2: quantum_reg[2] <= cfg_data[Q_W-1:0];
                    CFG_Q3: quantum_reg[3] <= cfg_data[Q_W-1:0];
                    CFG_P0: prio_reg[0] <= cfg_data[LVL_W-1:0];
                    CFG_P1: prio_reg[1] <= cfg_data[LVL_W-1:0];
                    CFG_P2: prio_reg[2] <= cfg_data[LVL_W-1:0];
                    CFG_P3: prio_reg[3] <= cfg_data[LVL_W-1:0];
                    default: ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (cmd.op)
                OP_ENQ:
                begin
                    if (enq_ok)
                    begin
                        fill_reg[cls_reg] <= fill_reg[cls_reg] + 1'b1;
                        if (fill_reg[cls_reg] == '0)
                        begin
                            deficit_reg[cls_reg] <= {1'b0, quantum_reg[cls_reg]};
                            if (rfill_reg[enq_lvl] < RFILL_W'(NUM_CLASSES))
                            begin
                                rfill_reg[enq_lvl] <= rfill_reg[enq_lvl] + 1'b1;
                            end
                        end
                    end
                end
                OP_FIND:
                begin
                    idx_reg      <= '0;
                    best_inf_reg <= 1'b1;
                end
                OP_EVAL, OP_RATIO:
                begin
                    if (cand_win)
                    begin
                        best_inf_reg <= 1'b0;
                    end
                    if (cmd.op == OP_EVAL && eval_div)
                    begin
                        div_cnt_reg <= '0;
                    end
                    else
                    begin
                        idx_reg <= idx_last ? '0 : idx_reg + 1'b1;
                    end
                end
                OP_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                end
                OP_ADD:
                begin
                    deficit_reg[mem_cls] <= (def_sum > {{(PROD_W + 1 - DEF_W){1'b0}}, DEFICIT_MAX})
                                            ? DEFICIT_MAX : def_sum[DEF_W-1:0];
                    idx_reg <= idx_last ? '0 : idx_reg + 1'b1;
                end
                OP_SEND:
                begin
                    deficit_reg[win_cls] <= (win_def >= {1'b0, win_len_reg})
                                            ? win_def - {1'b0, win_len_reg} : '0;
                    head_reg[win_cls] <= head_reg[win_cls] + 1'b1;
                    fill_reg[win_cls] <= fill_reg[win_cls] - 1'b1;
                    front_reg[lvl_reg] <= win_empties ? CLS_W'(1) : '0;
                    rfill_reg[lvl_reg] <= win_empties ? n_reg - 1'b1 : n_reg;
                end
                default: ;
            endcase
        end
    end

    // Update payload and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            cls_reg <= req_class;
            len_reg <= req_length;
        end
        case (cmd.op)
            OP_ENQ:
            begin
                if (enq_ok && fill_reg[cls_reg] == '0
                    && rfill_reg[enq_lvl] < RFILL_W'(NUM_CLASSES))
                begin
                    ring_reg[enq_lvl][ring_slot] <= cls_reg;
                end
            end
            OP_FIND:
            begin
                lvl_reg <= top_lvl;
                n_reg   <= rfill_reg[top_lvl];
            end
            OP_READ:
            begin
                member_reg[idx_reg] <= rd_cls;
                cur_reg             <= rd_cls;
            end
            OP_EVAL, OP_RATIO:
            begin
                if (cmd.op == OP_EVAL)
                begin
                    head_len_reg <= ram_rdata;
                    rem_reg      <= '0;
                    quo_reg      <= dividend;
                end
                if (cand_win)
                begin
                    best_reg    <= cand;
                    w_reg       <= idx_reg;
                    win_len_reg <= (cmd.op == OP_EVAL) ? ram_rdata : head_len_reg;
                end
            end
            OP_DIV:
            begin
                rem_reg <= div_ge ? LEN_W'(rem_sh - {1'b0, cur_q}) : rem_sh[LEN_W-1:0];
                quo_reg <= {quo_reg[LEN_W-2:0], div_ge};
            end
            OP_MUL:
            begin
                prod_reg <= rounds * quantum_reg[mem_cls];
            end
            OP_SEND:
            begin
                for (int i = 0; i < NUM_CLASSES; i++)
                begin
                    logic [RFILL_W:0] j;
                    j = RFILL_W'(w_reg) + (RFILL_W + 1)'(i);
                    if (j >= {1'b0, n_reg})
                    begin
                        j = j - {1'b0, n_reg};
                    end
                    if (RFILL_W'(i) < n_reg)
                    begin
                        ring_reg[lvl_reg][i] <= member_reg[j[CLS_W-1:0]];
                    end
                end
            end
            default: ;
        endcase
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_class_reg  <= (cmd.op == OP_SEND) ? win_cls : '0;
            out_len_reg    <= (cmd.op == OP_SEND) ? win_len_reg : '0;
        end
    end

    always_comb
    begin
        status.any_level = any_level;
        status.eval_div  = eval_div;
        status.idx_last  = idx_last;
        status.div_last  = (div_cnt_reg == DIVCNT_W'(LEN_W - 1));
        status.best_inf  = best_inf_reg;
        status.out_free  = !out_valid_reg || res_ready;
    end

    assign res_valid  = out_valid_reg;
    assign res_status = out_status_reg;
    assign res_class  = out_class_reg;
    assign res_length = out_len_reg;

    `PDWRR_ASSERT_NEXT(a_load_shows, out_load, out_valid_reg, "result load did not raise valid")
    `PDWRR_ASSERT_ALWAYS(a_ring_bound, rfill_reg[top_lvl] <= RFILL_W'(NUM_CLASSES), "ring overfull")
    `PDWRR_ASSERT_ALWAYS(a_send_finite, (cmd.op != OP_SEND) || !best_inf_reg, "served without winner")
    `PDWRR_ASSERT_NEXT(a_scan_wrap, (cmd.op == OP_ADD) && idx_last, idx_reg == '0, "member index did not wrap")
endmodule

>>> rtl/priority_dwrr_packet_scheduler.sv
// Top level of the strict-priority deficit weighted round robin packet scheduler.
//
//  channel  direction  handshake      payload
//  req      in         valid/ready    command, class_id, packet_length
//  res      out        valid/ready    status, served_class, served_length
//  cfg      in         cfg_we         cfg_index, cfg_data
//
// An enqueue is checked and, unless dropped, stored in its class queue. A dequeue
// scans the ring of the highest non-empty level one member after another; a
// member whose deficit does not cover its head packet runs the serial divider
// to count its missing rounds, then every member's deficit is credited in turn.
// A dequeue finds nothing to serve when all levels are empty or no member can pay.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled result holds in the output register; one new request is taken
// meanwhile and finishes once the register frees.
module priority_dwrr_packet_scheduler import pdwrr_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    pdwrr_req_if.sink            req,
    pdwrr_res_if.source          res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);
    ctrl_cmd_t  cmd;
    dp_status_t status;

    pdwrr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_command (req.command),
        .req_ready   (req.ready),
        .status      (status),
        .cmd         (cmd)
    );

    pdwrr_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .req_class  (req.class_id),
        .req_length (req.packet_length),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .res_valid  (res.valid),
        .res_ready  (res.ready),
        .res_status (res.status),
        .res_class  (res.served_class),
        .res_length (res.served_length)
    );
endmodule

>>> dv/priority_dwrr_packet_scheduler_test.sv
// Self-checking testbench of the strict-priority DWRR packet scheduler.
`timescale 1ns / 1ps

module priority_dwrr_packet_scheduler_test;
    import pdwrr_pkg::*;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;

    typedef struct {
        logic             command;
        logic [CLS_W-1:0] class_id;
        logic [LEN_W-1:0] packet_length;
    } sched_req_t;

    typedef struct {
        res_status_t      status;
        logic [CLS_W-1:0] served_class;
        logic [LEN_W-1:0] served_length;
    } sched_res_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    pdwrr_req_if req ();
    pdwrr_res_if res ();

    priority_dwrr_packet_scheduler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .res       (res.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: configuration, per-class FIFOs, deficits, per-level rings
    int unsigned quantum [NUM_CLASSES];
    int unsigned prio_lvl [NUM_CLASSES];
    logic [LEN_W-1:0] pkt_lens [NUM_CLASSES][QUEUE_DEPTH];
    int unsigned q_head [NUM_CLASSES];
    int unsigned q_fill [NUM_CLASSES];
    int unsigned deficit [NUM_CLASSES];
    int unsigned ring [PRIORITY_LEVELS][NUM_CLASSES];
    int unsigned ring_head [PRIORITY_LEVELS];
    int unsigned ring_count [PRIORITY_LEVELS];

    sched_req_t pending_reqs [$];
    sched_res_t expected_res [$];
    sched_req_t cur_req;
    int idle_pct = 36;
    int holdoff_asks = 0;
    int holdoff_done = 0;
    int holdoff_left = 0;
    int mismatches = 0;
    int stall_cycles = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic sched_res_t enqueue_pkt(int unsigned c, logic [LEN_W-1:0] len);
        sched_res_t r;
        int unsigned lvl;
        r.served_class = '0;
        r.served_length = '0;
        if (quantum[c] == 0) r.status = ST_DROP_UNCFG;
        else if (q_fill[c] >= QUEUE_DEPTH) r.status = ST_DROP_FULL;
        else
        begin
            r.status = ST_ENQUEUED;
            pkt_lens[c][(q_head[c] + q_fill[c]) % QUEUE_DEPTH] = len;
            q_fill[c]++;
            if (q_fill[c] == 1)
            begin
                lvl = prio_lvl[c];
                if (ring_count[lvl] < NUM_CLASSES)
                begin
                    ring[lvl][(ring_head[lvl] + ring_count[lvl]) % NUM_CLASSES] = c;
                    ring_count[lvl]++;
                end
                deficit[c] = quantum[c];
            end
        end
        return r;
    endfunction

    function automatic sched_res_t dequeue_pkt();
        sched_res_t r;
        int unsigned members [NUM_CLASSES];
        longint unsigned best, rounds, sum;
        longint unsigned hd, d, q;
        int lvl, n, w, c;
        r.status = ST_EMPTY;
        r.served_class = '0;
        r.served_length = '0;
        lvl = -1;
        for (int l = PRIORITY_LEVELS - 1; l >= 0; l--)
            if (lvl < 0 && ring_count[l] > 0) lvl = l;
        if (lvl < 0) return r;
        n = ring_count[lvl];
        best = 64'hFFFF_FFFF;
        w = 0;
        // Count the rounds each member needs to cover its head packet
        for (int i = 0; i < n; i++)
        begin
            c = ring[lvl][(ring_head[lvl] + i) % NUM_CLASSES];
            members[i] = c;
            q = quantum[c];
            d = deficit[c];
            hd = pkt_lens[c][q_head[c]];
            if (hd <= d) rounds = 0;
            else if (q == 0) rounds = 64'hFFFF_FFFF;
            else rounds = (hd - d + q - 1) / q;
            if (rounds < best)
            begin
                best = rounds;
                w = i;
            end
        end
        if (best == 64'hFFFF_FFFF) return r;
        // Credit every member for the rounds that passed, saturating
        for (int i = 0; i < n; i++)
        begin
            c = members[i];
            sum = deficit[c] + (best + (i < w ? 1 : 0)) * quantum[c];
            deficit[c] = (sum > 64'h1FFFF) ? 32'h1FFFF : int'(sum);
        end
        c = members[w];
        r.status = ST_DEQUEUED;
        r.served_class = CLS_W'(c);
        r.served_length = pkt_lens[c][q_head[c]];
        deficit[c] = (deficit[c] >= r.served_length) ? deficit[c] - r.served_length : 0;
        q_head[c] = (q_head[c] + 1) % QUEUE_DEPTH;
        q_fill[c]--;
        // Rotate the ring so the served class stands at the front
        for (int i = 0; i < n; i++) ring[lvl][i] = members[(w + i) % n];
        ring_head[lvl] = 0;
        ring_count[lvl] = n;
        if (q_fill[c] == 0)
        begin
            ring_head[lvl] = 1 % NUM_CLASSES;
            ring_count[lvl] = n - 1;
        end
        return r;
    endfunction

    // Driver: predict on acceptance, then present the next request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.command <= CMD_ENQ;
            req.class_id <= '0;
            req.packet_length <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                if (cur_req.command == CMD_ENQ)
                    expected_res.insert(expected_res.size(),
                                        enqueue_pkt(cur_req.class_id, cur_req.packet_length));
                else
                    expected_res.insert(expected_res.size(), dequeue_pkt());
            end
            if (req.valid && !req.ready)
                req.valid <= 1'b1;
            else if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                cur_req = pending_reqs[0];
                pending_reqs.delete(0);
                req.valid <= 1'b1;
                req.command <= cur_req.command;
                req.class_id <= cur_req.class_id;
                req.packet_length <= cur_req.packet_length;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // Monitor: check each result against the oldest prediction, drive ready
    always @(posedge clk or negedge rst_n)
    begin
        sched_res_t want;
        if (!rst_n)
            res.ready <= 1'b0;
        else
        begin
            if (res.valid && res.ready)
            begin
                if (expected_res.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result status=%0d class=%0d len=%0d",
                                 res.status, res.served_class, res.served_length);
                end
                else
                begin
                    want = expected_res[0];
                    expected_res.delete(0);
                    if (res.status !== want.status || res.served_class !== want.served_class
                        || res.served_length !== want.served_length)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: expected %s/%0d/%0d, got %0d/%0d/%0d",
                                     want.status.name(), want.served_class,
                                     want.served_length, res.status, res.served_class,
                                     res.served_length);
                    end
                end
            end
            if (holdoff_asks != holdoff_done)
            begin
                holdoff_done = holdoff_asks;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                res.ready <= 1'b0;
            end
            else
                res.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (res.valid && res.ready)) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, int unsigned value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(value);
        if (idx <= CFG_Q3) quantum[idx - CFG_Q0] = value & 16'hFFFF;
        else prio_lvl[idx - CFG_P0] = value & 3'h7;
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_req(logic cmd, int unsigned c, int unsigned len);
        sched_req_t r;
        r.command = cmd;
        r.class_id = CLS_W'(c);
        r.packet_length = LEN_W'(len);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_reqs.size() > 0 || req.valid || expected_res.size() > 0)
            @(negedge clk);
    endtask

    function automatic int unsigned rand_len();
        case ($urandom_range(3))
            0: return $urandom_range(65535);
            1: return $urandom_range(65535, 60000);
            default: return $urandom_range(3000);
        endcase
    endfunction

    function automatic int unsigned rand_quantum();
        case ($urandom_range(4))
            0: return 0;
            1: return 65535;
            2: return $urandom_range(65535);
            default: return $urandom_range(4000, 1);
        endcase
    endfunction

    // Stimulus: directed checks, then random phases with fresh settings
    initial
    begin
        int enq_pct;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_Q0;
        cfg_data = '0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            quantum[c] = 0;
            prio_lvl[c] = 0;
            q_head[c] = 0;
            q_fill[c] = 0;
            deficit[c] = 0;
        end
        for (int l = 0; l < PRIORITY_LEVELS; l++)
        begin
            ring_head[l] = 0;
            ring_count[l] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Empty dequeue and unconfigured drops right after reset
        add_req(CMD_DEQ, 3, 16'hFFFF);
        add_req(CMD_ENQ, 0, 0);
        add_req(CMD_ENQ, 3, 16'hFFFF);
        wait_idle();

        write_reg(CFG_Q0, 1);
        write_reg(CFG_Q1, 65535);
        write_reg(CFG_Q2, 100);
        write_reg(CFG_Q3, 0);
        write_reg(CFG_P0, 7);
        write_reg(CFG_P1, 7);
        write_reg(CFG_P2, 0);
        write_reg(CFG_P3, 3);
        end_writes();

        // Extremes of length, rotation within a level, strict priority
        add_req(CMD_ENQ, 0, 16'hFFFF);
        add_req(CMD_ENQ, 1, 0);
        add_req(CMD_ENQ, 1, 16'hFFFF);
        add_req(CMD_ENQ, 2, 5);
        add_req(CMD_ENQ, 2, 250);
        add_req(CMD_ENQ, 3, 7);
        add_req(CMD_DEQ, 0, 0);
        add_req(CMD_DEQ, 2, 16'hAAAA);
        add_req(CMD_DEQ, 1, 16'h5555);
        add_req(CMD_ENQ, 0, 2);
        add_req(CMD_ENQ, 0, 1);
        add_req(CMD_DEQ, 3, 16'hFFFF);
        wait_idle();

        // Zero a quantum while queued, move a class to another level
        write_reg(CFG_Q0, 0);
        write_reg(CFG_P2, 7);
        end_writes();
        for (int i = 0; i < 8; i++) add_req(CMD_DEQ, i % 4, 0);
        add_req(CMD_ENQ, 2, 1);
        wait_idle();

        // Random phases
        for (int ph = 0; ph < 8; ph++)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                write_reg(cfg_reg_t'(CFG_Q0 + c),
                          ph == 1 ? 65535 : (ph == 2 ? 1 : rand_quantum()));
                write_reg(cfg_reg_t'(CFG_P0 + c),
                          ph == 1 ? 7 : (ph == 2 ? 0 : $urandom_range(7)));
            end
            end_writes();
            idle_pct = (ph == 3) ? 0 : 36;
            enq_pct = (ph == 4 || ph == 6) ? 85 : ((ph == 7) ? 25 : 55);
            if (ph == 4)
            begin
                // Fill one class past its depth
                for (int i = 0; i < QUEUE_DEPTH + 3; i++) add_req(CMD_ENQ, 1, rand_len());
                holdoff_asks++;
            end
            for (int i = 0; i < 40; i++)
                add_req($urandom_range(99) < enq_pct ? CMD_ENQ : CMD_DEQ,
                        $urandom_range(NUM_CLASSES - 1), rand_len());
            wait_idle();
        end

        // Drain what is left
        write_reg(CFG_Q0, 700);
        write_reg(CFG_Q1, 65535);
        write_reg(CFG_Q2, 9);
        write_reg(CFG_Q3, 40000);
        end_writes();
        for (int i = 0; i < 40; i++) add_req(CMD_DEQ, $urandom_range(3), $urandom_range(65535));
        wait_idle();

        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_res.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/pdwrr_pkg.sv
rtl/pdwrr_if.sv
rtl/pdwrr_ram.sv
rtl/pdwrr_ctrl.sv
rtl/pdwrr_dp.sv
rtl/priority_dwrr_packet_scheduler.sv
dv/priority_dwrr_packet_scheduler_test.sv
